// File: rtl/core/gradient_line_rasterizer_unit_assert.svh
// assertion macros for the checker file of the line rasterizer
// expects signals named clock and reset in the scope that uses them
`ifndef GRADIENT_LINE_RASTERIZER_UNIT_ASSERT_SVH
`define GRADIENT_LINE_RASTERIZER_UNIT_ASSERT_SVH

// antecedent holds in a cycle, consequent holds in the same cycle
`define GLR_CHECK_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent holds in a cycle, consequent holds in the next cycle
`define GLR_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/glr_pkg.sv
// shared widths, codes and types of the gradient line rasterizer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package glr_pkg;

   // coordinate and fixed-point formats
   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int SPAN_W     = COORD_BITS + 1;
   localparam int ERR_W      = COORD_BITS + 3;
   localparam int DELTA_W    = 9;
   localparam int SCALE_W    = FRAC_BITS + 1;
   localparam int INC_W      = DELTA_W + SCALE_W;
   // a line takes fewer than 2^COORD_BITS steps, so this holds every running sum
   localparam int ACC_W      = INC_W + COORD_BITS;
   localparam int COLOR_W    = 24;
   localparam int NUM_CHAN   = 3;
   localparam int DIM_W      = 13;
   localparam int BPP_W      = 4;
   localparam int ADDR_W     = 27;
   localparam int WORD_W     = 32;

   localparam logic [FRAC_BITS-1:0] ROUND_HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

   // stream packing
   localparam int REQ_FIELDS_W = 4 * COORD_BITS + COLOR_W + NUM_CHAN * DELTA_W + SCALE_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = ADDR_W + WORD_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // request kinds
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_STEP  = 1'b1;

   // register map
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = DIM_W;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_PIX = 2'd2;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1024);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(768);
   localparam logic [BPP_W-1:0] BPP_RESET    = BPP_W'(4);

   // line setup carried by a start word
   typedef struct packed {
      logic [COORD_BITS-1:0]              x1;
      logic [COORD_BITS-1:0]              y1;
      logic [COORD_BITS-1:0]              x2;
      logic [COORD_BITS-1:0]              y2;
      logic [COLOR_W-1:0]                 color;
      logic [NUM_CHAN-1:0][DELTA_W-1:0]   delta;
      logic [SCALE_W-1:0]                 scale;
   } start_type;

   // snapshot of one pixel before it advances
   typedef struct packed {
      logic [DIM_W-1:0]                   x;
      logic [DIM_W-1:0]                   y;
      logic                               in_window;
      logic                               done;
      logic [NUM_CHAN-1:0][ACC_W-1:0]     acc;
      logic [COLOR_W-1:0]                 base;
   } pix_type;

endpackage

`default_nettype wire

// File: rtl/core/glr_stepper.sv
// bresenham line state, clip test and colour accumulators
// depends on glr_pkg
`timescale 1ns / 1ps
`default_nettype none

module glr_stepper
   import glr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load,
   input  wire logic               advance,
   input  wire start_type          start,
   input  wire logic [DIM_W-1:0]   win_w,
   input  wire logic [DIM_W-1:0]   win_h,
   output pix_type                 pix
);

   logic signed [COORD_BITS-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [COORD_BITS-1:0] tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic [SPAN_W-1:0]            span_x_ff, span_x_in, span_y_ff, span_y_in;
   logic                         dxn_ff, dxn_in, dyn_ff, dyn_in;
   logic signed [ERR_W-1:0]      err_ff, err_in;
   logic [COLOR_W-1:0]           base_ff, base_in;
   logic [NUM_CHAN-1:0][INC_W-1:0] inc_ff, inc_in;
   logic [NUM_CHAN-1:0][ACC_W-1:0] acc_ff, acc_in;

   logic                         active;
   logic                         on_x, on_y;
   logic signed [SPAN_W-1:0]     dx, dy;
   logic signed [ERR_W:0]        e2, neg_span_y, pos_span_x;
   logic                         move_x, move_y;
   logic signed [COORD_BITS-1:0] step_x, step_y;
   logic signed [INC_W-1:0]      scale_ext;

   assign active = !(cur_x_ff == tgt_x_ff && cur_y_ff == tgt_y_ff);

   // setup arithmetic for a start word
   assign dx        = $signed({start.x2[COORD_BITS-1], start.x2})
                    - $signed({start.x1[COORD_BITS-1], start.x1});
   assign dy        = $signed({start.y2[COORD_BITS-1], start.y2})
                    - $signed({start.y1[COORD_BITS-1], start.y1});
   assign scale_ext = $signed(INC_W'(start.scale));

   // error doubling and the two axis decisions
   assign e2         = $signed({err_ff, 1'b0});
   assign neg_span_y = -$signed((ERR_W + 1)'(span_y_ff));
   assign pos_span_x = $signed((ERR_W + 1)'(span_x_ff));
   assign move_x     = e2 > neg_span_y;
   assign move_y     = e2 < pos_span_x;
   assign step_x     = move_x ? (dxn_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1) : cur_x_ff;
   assign step_y     = move_y ? (dyn_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1) : cur_y_ff;

   always_comb begin
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      tgt_x_in  = tgt_x_ff;
      tgt_y_in  = tgt_y_ff;
      span_x_in = span_x_ff;
      span_y_in = span_y_ff;
      dxn_in    = dxn_ff;
      dyn_in    = dyn_ff;
      err_in    = err_ff;
      base_in   = base_ff;
      inc_in    = inc_ff;
      acc_in    = acc_ff;
      if (load) begin
         cur_x_in  = $signed(start.x1);
         cur_y_in  = $signed(start.y1);
         tgt_x_in  = $signed(start.x2);
         tgt_y_in  = $signed(start.y2);
         span_x_in = dx[SPAN_W-1] ? SPAN_W'(-dx) : SPAN_W'(dx);
         span_y_in = dy[SPAN_W-1] ? SPAN_W'(-dy) : SPAN_W'(dy);
         dxn_in    = dx[SPAN_W-1] || (dx == '0);
         dyn_in    = dy[SPAN_W-1] || (dy == '0);
         err_in    = $signed(ERR_W'(span_x_in)) - $signed(ERR_W'(span_y_in));
         base_in   = start.color;
         for (int i = 0; i < NUM_CHAN; i++) begin
            inc_in[i] = INC_W'($signed(INC_W'($signed(start.delta[i]))) * scale_ext);
            acc_in[i] = '0;
         end
      end else if (advance && active) begin
         cur_x_in = step_x;
         cur_y_in = step_y;
         err_in   = err_ff
                    - (move_x ? $signed(ERR_W'(span_y_ff)) : $signed(ERR_W'(0)))
                    + (move_y ? $signed(ERR_W'(span_x_ff)) : $signed(ERR_W'(0)));
         for (int i = 0; i < NUM_CHAN; i++) begin
            acc_in[i] = acc_ff[i] + ACC_W'($signed(inc_ff[i]));
         end
      end
   end

   // snapshot of the current pixel, taken before it advances
   assign on_x = (step_x == tgt_x_ff);
   assign on_y = (step_y == tgt_y_ff);

   always_comb begin
      pix.x         = DIM_W'($unsigned(cur_x_ff));
      pix.y         = DIM_W'($unsigned(cur_y_ff));
      pix.in_window = active && !cur_x_ff[COORD_BITS-1] && !cur_y_ff[COORD_BITS-1]
                      && (WORD_W'($unsigned(cur_x_ff)) < WORD_W'(win_w))
                      && (WORD_W'($unsigned(cur_y_ff)) < WORD_W'(win_h));
      pix.done      = active ? (on_x && on_y) : 1'b1;
      pix.acc       = acc_ff;
      pix.base      = base_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff  <= '0;
         cur_y_ff  <= '0;
         tgt_x_ff  <= '0;
         tgt_y_ff  <= '0;
         span_x_ff <= '0;
         span_y_ff <= '0;
         dxn_ff    <= 1'b0;
         dyn_ff    <= 1'b0;
         err_ff    <= '0;
         base_ff   <= '0;
         inc_ff    <= '0;
         acc_ff    <= '0;
      end else begin
         cur_x_ff  <= cur_x_in;
         cur_y_ff  <= cur_y_in;
         tgt_x_ff  <= tgt_x_in;
         tgt_y_ff  <= tgt_y_in;
         span_x_ff <= span_x_in;
         span_y_ff <= span_y_in;
         dxn_ff    <= dxn_in;
         dyn_ff    <= dyn_in;
         err_ff    <= err_in;
         base_ff   <= base_in;
         inc_ff    <= inc_in;
         acc_ff    <= acc_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/gradient_line_rasterizer_unit.sv
// top level of the gradient line rasterizer: stream ports, registers, pixel pipeline
// depends on glr_pkg and glr_stepper
//
//   channel   dir   handshake            payload
//   req_      in    tvalid / tready      tuser kind, tdata line setup (136 bits)
//   rsp_      out   tvalid / tready      tuser write enable, tlast line done,
//                                        tdata address and colour (64 bits)
//   csr_      in    wr_en, no wait       index 2 bits, data 13 bits
//
// one word per cycle on the request side unless stalled; a step word gives its
// result word through the stages snapshot, row/rounding and address/colour
// start words update the line state at once and give no result
// three valid-gated stages with a ready chain: bubbles collapse, so a result
// held by a stalled consumer does not stop new words until the stages fill
// reset is synchronous: line state clears to an idle zero-length line,
// registers return to 1024 x 768 at 4 bytes per pixel
`timescale 1ns / 1ps
`default_nettype none

module gradient_line_rasterizer_unit
   import glr_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request words
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   // start_x, start_y, end_x, end_y, start_color, high_delta, mid_delta,
   // low_delta, step_scale, zero pad
   input  wire logic [REQ_DATA_W-1:0]   req_tdata,
   // req_type
   input  wire logic                    req_tuser,
   // result words
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   // pixel_address, pixel_color, zero pad
   output logic [RSP_DATA_W-1:0]        rsp_tdata,
   // write_enable
   output logic                         rsp_tuser,
   // line_done
   output logic                         rsp_tlast,
   // register writes
   input  wire logic                    csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int ROW_FULL_W  = 2 * DIM_W + 1;
   localparam int ADDR_FULL_W = ADDR_W + BPP_W;

   // configuration registers
   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic [BPP_W-1:0] bpp_ff, bpp_in;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      bpp_in    = bpp_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WINDOW_WIDTH:  width_in  = csr_wdata;
            CSR_WINDOW_HEIGHT: height_in = csr_wdata;
            CSR_BYTES_PER_PIX: bpp_in    = BPP_W'(csr_wdata);
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         bpp_ff    <= BPP_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         bpp_ff    <= bpp_in;
      end
   end

   // request unpacking, lowest field first
   start_type start;
   localparam int OFS_Y1 = COORD_BITS;
   localparam int OFS_X2 = 2 * COORD_BITS;
   localparam int OFS_Y2 = 3 * COORD_BITS;
   localparam int OFS_C  = 4 * COORD_BITS;
   localparam int OFS_D  = OFS_C + COLOR_W;
   localparam int OFS_S  = OFS_D + NUM_CHAN * DELTA_W;

   always_comb begin
      start.x1    = req_tdata[OFS_Y1-1:0];
      start.y1    = req_tdata[OFS_X2-1:OFS_Y1];
      start.x2    = req_tdata[OFS_Y2-1:OFS_X2];
      start.y2    = req_tdata[OFS_C-1:OFS_Y2];
      start.color = req_tdata[OFS_D-1:OFS_C];
      for (int i = 0; i < NUM_CHAN; i++) begin
         start.delta[i] = req_tdata[OFS_D + i*DELTA_W +: DELTA_W];
      end
      start.scale = req_tdata[OFS_S +: SCALE_W];
   end

   // ready chain: each stage takes a word when it is empty or moving on
   logic s1_valid_ff, s1_valid_in, s2_valid_ff, s2_valid_in, rsp_valid_ff, rsp_valid_in;
   logic ready1, ready2, ready3;
   logic req_fire, load, advance;

   assign ready3     = !rsp_valid_ff || rsp_tready;
   assign ready2     = !s2_valid_ff || ready3;
   assign ready1     = !s1_valid_ff || ready2;
   assign req_tready = ready1;
   assign req_fire   = req_tvalid && ready1;
   assign load       = req_fire && (req_tuser == REQ_START);
   assign advance    = req_fire && (req_tuser == REQ_STEP);

   pix_type pix;

   glr_stepper u_stepper (
      .clock   (clock),
      .reset   (reset),
      .load    (load),
      .advance (advance),
      .start   (start),
      .win_w   (width_ff),
      .win_h   (height_ff),
      .pix     (pix)
   );

   // round to nearest, exact half toward zero, on the magnitude
   function automatic logic [WORD_W-1:0] round_term(input logic [ACC_W-1:0] acc);
      logic                        neg;
      logic [ACC_W-1:0]            mag;
      logic [ACC_W-FRAC_BITS-1:0]  q;
      logic [FRAC_BITS-1:0]        r;
      logic [WORD_W-1:0]           v;
      neg = acc[ACC_W-1];
      mag = neg ? (~acc + 1'b1) : acc;
      q   = mag[ACC_W-1:FRAC_BITS];
      r   = mag[FRAC_BITS-1:0];
      if (r > ROUND_HALF) begin
         q = q + 1'b1;
      end
      v = WORD_W'(q);
      return neg ? (~v + 1'b1) : v;
   endfunction

   // stage 1: pixel snapshot
   pix_type s1_pix_ff, s1_pix_in;

   assign s1_valid_in = ready1 ? advance : s1_valid_ff;
   assign s1_pix_in   = advance ? pix : s1_pix_ff;

   // stage 2: row index and rounded channel terms
   logic [ADDR_W-1:0]               s2_row_ff, s2_row_in;
   logic [NUM_CHAN-1:0][WORD_W-1:0] s2_term_ff, s2_term_in;
   logic                            s2_inside_ff, s2_inside_in, s2_done_ff, s2_done_in;
   logic [COLOR_W-1:0]              s2_base_ff, s2_base_in;
   logic [ROW_FULL_W-1:0]           row_full;
   logic                            s2_load;

   assign s2_load     = ready2 && s1_valid_ff;
   assign s2_valid_in = ready2 ? s1_valid_ff : s2_valid_ff;
   assign row_full    = ROW_FULL_W'(s1_pix_ff.y) * ROW_FULL_W'(width_ff)
                      + ROW_FULL_W'(s1_pix_ff.x);

   always_comb begin
      s2_row_in    = s2_row_ff;
      s2_term_in   = s2_term_ff;
      s2_inside_in = s2_inside_ff;
      s2_done_in   = s2_done_ff;
      s2_base_in   = s2_base_ff;
      if (s2_load) begin
         s2_row_in    = ADDR_W'(row_full);
         for (int i = 0; i < NUM_CHAN; i++) begin
            s2_term_in[i] = round_term(s1_pix_ff.acc[i]);
         end
         s2_inside_in = s1_pix_ff.in_window;
         s2_done_in   = s1_pix_ff.done;
         s2_base_in   = s1_pix_ff.base;
      end
   end

   // stage 3: byte address and colour word, held for the consumer
   logic [ADDR_W-1:0]      rsp_addr_ff, rsp_addr_in;
   logic [WORD_W-1:0]      rsp_color_ff, rsp_color_in;
   logic                   rsp_we_ff, rsp_we_in, rsp_done_ff, rsp_done_in;
   logic [ADDR_FULL_W-1:0] addr_full;
   logic                   s3_load;

   assign s3_load      = ready3 && s2_valid_ff;
   assign rsp_valid_in = ready3 ? s2_valid_ff : rsp_valid_ff;
   assign addr_full    = ADDR_FULL_W'(s2_row_ff) * ADDR_FULL_W'(bpp_ff);

   always_comb begin
      rsp_addr_in  = rsp_addr_ff;
      rsp_color_in = rsp_color_ff;
      rsp_we_in    = rsp_we_ff;
      rsp_done_in  = rsp_done_ff;
      if (s3_load) begin
         rsp_addr_in  = s2_inside_ff ? addr_full[ADDR_W-1:0] : '0;
         // channel terms land at bit 16, 8 and 0, sum wraps at the word width
         rsp_color_in = WORD_W'(s2_base_ff) + (s2_term_ff[0] << 16)
                      + (s2_term_ff[1] << 8) + s2_term_ff[2];
         rsp_we_in    = s2_inside_ff;
         rsp_done_in  = s2_done_ff;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      s1_pix_ff    <= s1_pix_in;
      s2_row_ff    <= s2_row_in;
      s2_term_ff   <= s2_term_in;
      s2_inside_ff <= s2_inside_in;
      s2_done_ff   <= s2_done_in;
      s2_base_ff   <= s2_base_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_color_ff <= rsp_color_in;
      rsp_we_ff    <= rsp_we_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_FIELDS_W){1'b0}}, rsp_color_ff, rsp_addr_ff};
   assign rsp_tuser  = rsp_we_ff;
   assign rsp_tlast  = rsp_done_ff;

endmodule

`default_nettype wire

// File: rtl/core/glr_checker.sv
// port-level checks of the gradient line rasterizer, bound to the top level
// depends on glr_pkg and gradient_line_rasterizer_unit_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "gradient_line_rasterizer_unit_assert.svh"

module glr_checker
   import glr_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_tready,
   input wire logic                    rsp_tvalid,
   input wire logic                    rsp_tready,
   input wire logic [RSP_DATA_W-1:0]   rsp_tdata,
   input wire logic                    rsp_tuser,
   input wire logic                    rsp_tlast
);

   // a stalled result word keeps its content
   `GLR_CHECK_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "result word changed while stalled")

   // a pixel that is not written carries a zero address
   `GLR_CHECK_IMPLY(a_clip_addr, rsp_tvalid && !rsp_tuser, rsp_tdata[ADDR_W-1:0] == '0, "clipped pixel with nonzero address")

   // pipeline is empty right after reset
   `GLR_CHECK_IMPLY(a_rst_empty, $past(reset), !rsp_tvalid, "result word right after reset")

   // request side is open right after reset
   `GLR_CHECK_IMPLY(a_rst_ready, $past(reset), req_tready, "request side blocked after reset")

endmodule

bind gradient_line_rasterizer_unit glr_checker u_glr_checker (.*);

`default_nettype wire
